@@ sv/racf_pkg.sv @@
// package: shared types, constants and command/status structs
`timescale 1ns / 1ps
package racf_pkg;

   localparam int unsigned PART_W    = 31;
   localparam int unsigned TOL_W     = 32;
   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_W     = 32;
   localparam int unsigned STEP_MAX  = 128;
   localparam int unsigned STEP_W    = 8;
   localparam logic [63:0] TERM_LIMIT_DEF = 64'd2147483647;
   localparam logic [PART_W-1:0] MAX_PART_RESET = 31'h7fffffff;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_PART  = 1'b0,
      CSR_TOLERANCE = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_WAIT,
      ST_UPDATE,
      ST_ERR,
      ST_PD_WAIT,
      ST_CMP_A,
      ST_XA_WAIT,
      ST_CMP_B,
      ST_XB_WAIT,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0]       numerator;
      logic [PART_W-1:0] denominator;
      logic              term_overflow;
   } rsp_word_type;

   typedef struct packed {
      logic load;      // latch input word, reset expansion
      logic div_start; // begin serial division num / den
      logic div_step;  // one quotient bit
      logic update;    // form next convergent
      logic err;       // start multiply p * d
      logic mul_step;  // one 32-bit chunk of the running multiply
      logic cmp_a;     // take error, start e * d1
      logic cmp_b;     // take e * d1, start e_prev * d
      logic accept;    // keep new convergent, advance remainder
      logic rollback;  // restore previous convergent
      logic ovf;       // term overflow result
      logic finish;    // load output register
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic term_big;
      logic bound_fail;
      logic first;
      logic no_gain;
      logic rem_zero;
      logic tol_met;
      logic guard_out;
   } status_type;

endpackage

@@ sv/racf_if.sv @@
// valid/ready channel interface with payload
`timescale 1ns / 1ps
interface racf_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/racf_ctrl.sv @@
// controller state machine for the expansion sequence
`timescale 1ns / 1ps
module racf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    out_free,
   input  racf_pkg::status_type    stat,
   output racf_pkg::cmd_type       cmd
);
   racf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= racf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         racf_pkg::ST_IDLE:     if (in_valid) state_in = racf_pkg::ST_DIV;
         racf_pkg::ST_DIV:      state_in = racf_pkg::ST_DIV_WAIT;
         racf_pkg::ST_DIV_WAIT: if (stat.div_done) state_in = racf_pkg::ST_UPDATE;
         racf_pkg::ST_UPDATE: begin
            if (stat.term_big) state_in = racf_pkg::ST_DONE;
            else state_in = racf_pkg::ST_ERR;
         end
         racf_pkg::ST_ERR: begin
            if (stat.bound_fail) state_in = racf_pkg::ST_DONE;
            else state_in = racf_pkg::ST_PD_WAIT;
         end
         racf_pkg::ST_PD_WAIT:  if (stat.mul_done) state_in = racf_pkg::ST_CMP_A;
         racf_pkg::ST_CMP_A:    state_in = racf_pkg::ST_XA_WAIT;
         racf_pkg::ST_XA_WAIT:  if (stat.mul_done) state_in = racf_pkg::ST_CMP_B;
         racf_pkg::ST_CMP_B:    state_in = racf_pkg::ST_XB_WAIT;
         racf_pkg::ST_XB_WAIT:  if (stat.mul_done) state_in = racf_pkg::ST_DECIDE;
         racf_pkg::ST_DECIDE: begin
            if ((!stat.first && stat.no_gain) || stat.rem_zero || stat.tol_met
                || stat.guard_out) begin
               state_in = racf_pkg::ST_DONE;
            end else begin
               state_in = racf_pkg::ST_DIV;
            end
         end
         racf_pkg::ST_DONE:     if (out_free) state_in = racf_pkg::ST_IDLE;
         default:               state_in = racf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff) inside
         racf_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         racf_pkg::ST_DIV:      cmd.div_start = 1'b1;
         racf_pkg::ST_DIV_WAIT: cmd.div_step = 1'b1;
         racf_pkg::ST_UPDATE: begin
            cmd.update = !stat.term_big;
            cmd.ovf    = stat.term_big;
         end
         racf_pkg::ST_ERR: begin
            cmd.err      = !stat.bound_fail;
            cmd.rollback = stat.bound_fail;
         end
         racf_pkg::ST_PD_WAIT, racf_pkg::ST_XA_WAIT, racf_pkg::ST_XB_WAIT:
            cmd.mul_step = 1'b1;
         racf_pkg::ST_CMP_A:    cmd.cmp_a = 1'b1;
         racf_pkg::ST_CMP_B:    cmd.cmp_b = 1'b1;
         racf_pkg::ST_DECIDE: begin
            if (!stat.first && stat.no_gain) cmd.rollback = 1'b1;
            else cmd.accept = 1'b1;
         end
         racf_pkg::ST_DONE:     cmd.finish = out_free;
         default: ;
      endcase
   end
endmodule

@@ sv/racf_dp.sv @@
// datapath: serial divider, convergent registers, error compare
`timescale 1ns / 1ps
module racf_dp #(
   parameter logic [63:0] TERM_LIMIT = racf_pkg::TERM_LIMIT_DEF
) (
   input  logic                          clock,
   input  racf_pkg::cmd_type             cmd,
   output racf_pkg::status_type          stat,
   input  logic [racf_pkg::VALUE_W-1:0]  value_in,
   input  logic [racf_pkg::PART_W-1:0]   max_part,
   input  logic [racf_pkg::TOL_W-1:0]    tolerance,
   output logic signed [31:0]            numerator,
   output logic [racf_pkg::PART_W-1:0]   denominator,
   output logic                          term_overflow
);
   // expansion state
   logic        neg_ff;
   logic [63:0] p_ff;
   logic [63:0] num_ff, den_ff;
   logic [63:0] n_ff, d_ff, n1_ff, d1_ff;
   logic [63:0] n_in, d_in;
   logic        first_ff, ovf_ff;
   logic [127:0] eprev_ff, e_ff;
   logic [racf_pkg::STEP_W-1:0] guard_ff;
   // divider
   logic [63:0] q_ff, r_ff, sh_ff;
   logic [6:0]  dcnt_ff;
   logic [64:0] r_try;
   // shared 32x32 multiply-accumulate, most significant chunk first
   logic [95:0]  opnd_ff;
   logic [31:0]  fac_ff;
   logic [1:0]   mcnt_ff;
   logic [127:0] acc_ff, xa_ff;
   logic [63:0]  chunk_prod;
   logic [63:0]  qn_prod, qd_prod, tol_prod;
   logic [127:0] nq, e_next;

   assign r_try = {r_ff, sh_ff[63]} - {1'b0, den_ff};
   // quotient fits 32 bits and the kept convergent 31 bits once past the limits
   assign qn_prod    = {32'd0, q_ff[31:0]} * {32'd0, n_ff[31:0]};
   assign qd_prod    = {32'd0, q_ff[31:0]} * {32'd0, d_ff[31:0]};
   assign n_in       = qn_prod + n1_ff;
   assign d_in       = qd_prod + d1_ff;
   assign nq         = {32'd0, n_ff, 32'd0};
   assign chunk_prod = {32'd0, opnd_ff[95:64]} * {32'd0, fac_ff};
   assign e_next     = (acc_ff >= nq) ? (acc_ff - nq) : (nq - acc_ff);
   assign tol_prod   = {32'd0, tolerance} * {32'd0, d_ff[31:0]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff   <= value_in[63];
         p_ff     <= value_in[63] ? (~value_in + 64'd1) : value_in;
         num_ff   <= value_in[63] ? (~value_in + 64'd1) : value_in;
         den_ff   <= 64'h1_0000_0000;
         n_ff     <= 64'd1;
         d_ff     <= 64'd0;
         n1_ff    <= 64'd0;
         d1_ff    <= 64'd1;
         first_ff <= 1'b1;
         ovf_ff   <= 1'b0;
         eprev_ff <= '0;
         guard_ff <= '0;
      end
      if (cmd.div_start) begin
         q_ff    <= '0;
         r_ff    <= '0;
         sh_ff   <= num_ff;
         dcnt_ff <= 7'd0;
      end
      if (cmd.div_step && !dcnt_ff[6]) begin
         sh_ff   <= {sh_ff[62:0], 1'b0};
         dcnt_ff <= dcnt_ff + 7'd1;
         if (!r_try[64]) begin
            r_ff <= r_try[63:0];
            q_ff <= {q_ff[62:0], 1'b1};
         end else begin
            r_ff <= {r_ff[62:0], sh_ff[63]};
            q_ff <= {q_ff[62:0], 1'b0};
         end
      end
      if (cmd.update) begin
         // n_ff/d_ff become new convergent, n1/d1 the previous one
         n1_ff <= n_ff;
         d1_ff <= d_ff;
         n_ff  <= n_in;
         d_ff  <= d_in;
      end
      if (cmd.err) begin
         opnd_ff <= {32'd0, p_ff};
         fac_ff  <= d_ff[31:0];
         acc_ff  <= '0;
         mcnt_ff <= 2'd3;
      end
      if (cmd.mul_step && mcnt_ff != 2'd0) begin
         opnd_ff <= {opnd_ff[63:0], 32'd0};
         acc_ff  <= {acc_ff[95:0], 32'd0} + {64'd0, chunk_prod};
         mcnt_ff <= mcnt_ff - 2'd1;
      end
      if (cmd.cmp_a) begin
         // error below 2^95, so three chunks cover it
         e_ff    <= e_next;
         opnd_ff <= e_next[95:0];
         fac_ff  <= d1_ff[31:0];
         acc_ff  <= '0;
         mcnt_ff <= 2'd3;
      end
      if (cmd.cmp_b) begin
         xa_ff   <= acc_ff;
         opnd_ff <= eprev_ff[95:0];
         fac_ff  <= d_ff[31:0];
         acc_ff  <= '0;
         mcnt_ff <= 2'd3;
      end
      if (cmd.accept) begin
         first_ff <= 1'b0;
         eprev_ff <= e_ff;
         num_ff   <= den_ff;
         den_ff   <= r_ff;
         guard_ff <= guard_ff + 1'b1;
      end
      if (cmd.rollback) begin
         n_ff <= n1_ff;
         d_ff <= d1_ff;
      end
      if (cmd.ovf) begin
         ovf_ff <= 1'b1;
      end
   end

   always_comb begin
      stat.div_done   = dcnt_ff[6];
      stat.mul_done   = mcnt_ff == 2'd0;
      stat.term_big   = q_ff > TERM_LIMIT;
      stat.bound_fail = (n_ff > {33'd0, max_part}) || (d_ff > {33'd0, max_part});
      stat.first      = first_ff;
      stat.no_gain    = xa_ff >= acc_ff;
      stat.rem_zero   = r_ff == 64'd0;
      stat.tol_met    = (e_ff[127:64] == 64'd0) && (e_ff[63:0] <= tol_prod);
      stat.guard_out  = guard_ff == racf_pkg::STEP_W'(racf_pkg::STEP_MAX - 1);
   end

   assign numerator     = ovf_ff ? 32'sd0 : (neg_ff ? -$signed(n_ff[31:0])
                                                      : $signed(n_ff[31:0]));
   assign denominator   = ovf_ff ? '0 : d_ff[racf_pkg::PART_W-1:0];
   assign term_overflow = ovf_ff;
endmodule

@@ sv/rational_approx_contfrac_core.sv @@
// top level: best rational approximation by continued fractions
`timescale 1ns / 1ps
//  channel  dir  payload                                    handshake
//  req      in   value_in[63:0] signed Q31.32               valid/ready
//  rsp      out  numerator[31:0], denominator[30:0], ovf    valid/ready
//  csr      in   index[0], data[31:0]                       write enable
// one word at a time; each expansion step runs the bit-serial 64-bit divider and
// three passes of the 32x32 multiplier, plus control states; the number of steps
// per word is bounded by STEP_MAX
// the result sits in an output register; a result is only loaded once the last one leaves
// reset is synchronous and returns max_part and tolerance to their defaults
module rational_approx_contfrac_core #(
   parameter logic [63:0] TERM_LIMIT = racf_pkg::TERM_LIMIT_DEF
) (
   input  logic clock,
   input  logic reset,
   racf_if.sink   req,
   racf_if.source rsp,
   input  logic                              csr_we,
   input  logic [racf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [racf_pkg::CSR_W-1:0]        csr_data
);
   logic [racf_pkg::PART_W-1:0] max_part_ff;
   logic [racf_pkg::TOL_W-1:0]  tolerance_ff;
   racf_pkg::cmd_type    cmd;
   racf_pkg::status_type stat;
   logic signed [31:0]          numerator;
   logic [racf_pkg::PART_W-1:0] denominator;
   logic                        term_overflow;
   logic                        rsp_valid_ff;
   logic                        out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_part_ff  <= racf_pkg::MAX_PART_RESET;
         tolerance_ff <= '0;
      end else if (csr_we) begin
         unique case (racf_pkg::csr_idx_type'(csr_index))
            racf_pkg::CSR_MAX_PART:  max_part_ff  <= csr_data[racf_pkg::PART_W-1:0];
            racf_pkg::CSR_TOLERANCE: tolerance_ff <= csr_data[racf_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   racf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .out_free (out_free),
      .stat     (stat),
      .cmd      (cmd)
   );

   racf_dp #(.TERM_LIMIT(TERM_LIMIT)) u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .stat          (stat),
      .value_in      (req.data.value_in),
      .max_part      (max_part_ff),
      .tolerance     (tolerance_ff),
      .numerator     (numerator),
      .denominator   (denominator),
      .term_overflow (term_overflow)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp.data.numerator     <= numerator;
         rsp.data.denominator   <= denominator;
         rsp.data.term_overflow <= term_overflow;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   // a word is only taken while no expansion is in flight
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.div_step && !cmd.finish)
      else $error("load during expansion");
   // rollback and accept never together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.rollback))
      else $error("accept and rollback together");
   // finished word never overwrites an unread one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp.ready))
      else $error("output overrun");
endmodule
